>>> design/bwfc_pkg.sv
// ----------------------------------------------------------------------------
// bwfc_pkg
// Shared types and constants of the binary-weight fully connected layer.
// ----------------------------------------------------------------------------
`default_nettype none

package bwfc_pkg;

    // Layer dimensions and field widths.
    localparam int MAX_OUTPUTS = 64;
    localparam int MAX_INPUTS  = 1024;
    localparam int ROW_W       = $clog2(MAX_OUTPUTS);
    localparam int COL_W       = $clog2(MAX_INPUTS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = MAX_OUTPUTS * MAX_INPUTS;
    localparam int VAL_W       = 16;
    localparam int OUT_W       = 48;
    localparam int K_W         = 11;
    localparam int N_W         = 7;
    localparam int SUM_W       = 26;
    localparam int ACC_W       = 43;
    localparam int QDEPTH      = 4;

    // Input kind codes.
    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_BIAS   = 2'd1;
    localparam logic [1:0] KIND_ACT    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_USE_BIN  = 3'd0;
    localparam logic [2:0] REG_USE_SCL  = 3'd1;
    localparam logic [2:0] REG_POS_VAL  = 3'd2;
    localparam logic [2:0] REG_NEG_VAL  = 3'd3;
    localparam logic [2:0] REG_BIAS_EN  = 3'd4;
    localparam logic [2:0] REG_K_IN_USE = 3'd5;
    localparam logic [2:0] REG_N_IN_USE = 3'd6;

    // Command operations passed from the front end to the engine.
    typedef enum logic [1:0] {
        OP_WEIGHT,
        OP_BIAS,
        OP_ACT,
        OP_RUN
    } t_op;

    typedef struct packed {
        logic [1:0]              kind;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]        out_index;
        logic signed [OUT_W-1:0] out_value;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        t_op                     op;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // Configuration in force, lengths already clamped to their legal range.
    typedef struct packed {
        logic                    use_bin;
        logic                    use_scale;
        logic signed [VAL_W-1:0] pos_value;
        logic signed [VAL_W-1:0] neg_value;
        logic                    bias_en;
        logic [K_W-1:0]          k_eff;
        logic [N_W-1:0]          n_eff;
    } t_cfg;

endpackage

`default_nettype wire

>>> design/bwfc_front.sv
// ----------------------------------------------------------------------------
// bwfc_front
// Accepts input beats, drops unused kinds and tags the vector-closing
// activation as a run command for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfc_front (
    input  wire logic               i_in_valid,
    input  wire bwfc_pkg::t_in_item i_in_item,
    output logic                    o_in_stall,
    input  wire logic               i_q_full,
    input  wire logic               i_clearing,
    input  wire bwfc_pkg::t_cfg     i_cfg,
    output logic                    o_push,
    output bwfc_pkg::t_cmd          o_cmd
);
    import bwfc_pkg::*;

    logic [K_W-1:0] w_k_m1;
    logic           w_accept;

    // Hold the input off while the queue is full or the store is being cleared.
    assign o_in_stall = i_q_full || i_clearing;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_k_m1     = i_cfg.k_eff - K_W'(1);

    // Classify the beat into a command.
    always_comb begin
        o_cmd.row   = i_in_item.row;
        o_cmd.col   = i_in_item.col;
        o_cmd.value = i_in_item.value;
        o_cmd.op    = OP_ACT;
        o_push      = w_accept;
        unique case (i_in_item.kind)
            KIND_WEIGHT: o_cmd.op = OP_WEIGHT;
            KIND_BIAS:   o_cmd.op = OP_BIAS;
            KIND_ACT: begin
                o_cmd.op = (i_in_item.col == w_k_m1[COL_W-1:0]) ? OP_RUN : OP_ACT;
            end
            default: o_push = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/bwfc_queue.sv
// ----------------------------------------------------------------------------
// bwfc_queue
// Short command queue that lets the front end and the engine stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bwfc_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output bwfc_pkg::t_cmd      o_cmd,
    output logic                o_empty,
    output logic                o_full
);
    import bwfc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd             r_slot [0:QDEPTH-1];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;

    assign o_cmd   = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QDEPTH));

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    // Payload slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/bwfc_div.sv
// ----------------------------------------------------------------------------
// bwfc_div
// Restoring divider, one quotient bit a cycle, for the row scale.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bwfc_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [bwfc_pkg::K_W-1:0]   i_divisor,
    output logic                            o_done,
    output logic [bwfc_pkg::SUM_W-1:0]      o_quot
);
    import bwfc_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic [SUM_W-1:0] r_quo;
    logic [K_W-1:0]   r_rem;
    logic [K_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [K_W:0]     w_trial;
    logic [K_W:0]     w_diff;
    logic             w_ge;

    assign o_done  = r_done;
    assign o_quot  = r_quo;
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Shift-subtract iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[K_W-1:0] : w_trial[K_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bwfc_back.sv
// ----------------------------------------------------------------------------
// bwfc_back
// Engine: owns the weight, effective weight, activation and bias stores,
// rebuilds the effective weights and runs the dot products row by row.
// ----------------------------------------------------------------------------
`default_nettype none

module bwfc_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bwfc_pkg::t_cfg             i_cfg,
    input  wire logic                       i_q_empty,
    input  wire bwfc_pkg::t_cmd             i_q_cmd,
    output logic                            o_q_pop,
    output logic                            o_clearing,
    output logic                            o_div_start,
    output logic [bwfc_pkg::SUM_W-1:0]      o_div_dividend,
    input  wire logic                       i_div_done,
    input  wire logic [bwfc_pkg::SUM_W-1:0] i_div_quot,
    output logic                            o_out_valid,
    output bwfc_pkg::t_out_item             o_out_item,
    input  wire logic                       i_out_stall
);
    import bwfc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_SUM_WAIT,
        ST_DIV_START,
        ST_DIV,
        ST_BUILD,
        ST_BUILD_WAIT,
        ST_DOT,
        ST_DOT_WAIT
    } t_state;

    // Stores.
    logic signed [VAL_W-1:0] r_wmem [0:STORE_DEPTH-1];
    logic signed [VAL_W-1:0] r_emem [0:STORE_DEPTH-1];
    logic signed [VAL_W-1:0] r_amem [0:MAX_INPUTS-1];
    logic signed [VAL_W-1:0] r_bmem [0:MAX_OUTPUTS-1];
    logic signed [VAL_W-1:0] r_wq;
    logic signed [VAL_W-1:0] r_eq;
    logic signed [VAL_W-1:0] r_aq;
    logic signed [VAL_W-1:0] r_bq;

    // Control and datapath registers.
    t_state                  r_state;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic                    r_ready;
    logic [MAX_OUTPUTS-1:0]  r_bias_vld;
    logic [VAL_W-1:0]        r_scale;
    logic [SUM_W-1:0]        r_sum;
    logic [ADDR_W-1:0]       r_clr;
    logic                    r_s1_valid;
    logic                    r_s1_first;
    logic                    r_s1_last;
    logic [COL_W-1:0]        r_s1_col;
    logic                    r_s2_valid;
    logic                    r_s2_first;
    logic                    r_s2_last;
    logic [COL_W-1:0]        r_s2_col;
    logic                    r_s3_valid;
    logic                    r_s3_last;
    logic signed [31:0]      r_prod;
    logic signed [32:0]      r_bprod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic                    w_pop;
    logic                    w_out_take;
    logic [K_W-1:0]          w_k_m1;
    logic [N_W-1:0]          w_n_m1;
    logic                    w_col_last;
    logic                    w_row_last;
    logic                    w_dot_go;
    logic                    w_issue;
    logic                    w_eff_we;
    logic [ADDR_W-1:0]       w_eff_wa;
    logic signed [VAL_W-1:0] w_eff_wd;
    logic [VAL_W-1:0]        w_abs;
    logic signed [VAL_W-1:0] w_code;
    logic signed [33:0]      w_adj;
    logic signed [25:0]      w_trunc;
    logic signed [ACC_W-1:0] w_bias_term;
    logic signed [ACC_W-1:0] w_final;

    assign o_q_pop        = w_pop;
    assign o_clearing     = (r_state == ST_CLEAR);
    assign o_div_start    = (r_state == ST_DIV_START);
    assign o_div_dividend = r_sum;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

    // Sequencing conditions.
    always_comb begin
        w_pop      = (r_state == ST_IDLE) && !i_q_empty;
        w_out_take = r_out_valid && !i_out_stall;
        w_k_m1     = i_cfg.k_eff - K_W'(1);
        w_n_m1     = i_cfg.n_eff - N_W'(1);
        w_col_last = (r_col == w_k_m1[COL_W-1:0]);
        w_row_last = (r_row == w_n_m1[ROW_W-1:0]);
        w_dot_go   = (r_col != '0) || !r_out_valid || w_out_take;
        unique case (r_state)
            ST_SUM, ST_BUILD: w_issue = 1'b1;
            ST_DOT:           w_issue = w_dot_go;
            default:          w_issue = 1'b0;
        endcase
    end

    // Weight rebuild arithmetic: magnitude, code, truncation toward zero, clamp.
    always_comb begin
        w_abs   = r_wq[VAL_W-1] ? (~r_wq + VAL_W'(1)) : r_wq;
        w_code  = (r_wq >= 0) ? i_cfg.pos_value : i_cfg.neg_value;
        w_adj   = {r_bprod[32], r_bprod} + (r_bprod[32] ? 34'sd255 : 34'sd0);
        w_trunc = 26'(w_adj >>> 8);
        if (w_trunc > 26'sd32767) begin
            w_eff_wd = 16'sh7fff;
        end else if (w_trunc < -26'sd32768) begin
            w_eff_wd = -16'sh8000;
        end else begin
            w_eff_wd = w_trunc[VAL_W-1:0];
        end
        if (r_state == ST_CLEAR) begin
            w_eff_wd = '0;
        end
        w_eff_we = (r_state == ST_CLEAR) ||
                   (r_s2_valid && (r_state == ST_BUILD || r_state == ST_BUILD_WAIT));
        w_eff_wa = (r_state == ST_CLEAR) ? r_clr : {r_row, r_s2_col};
    end

    // Bias term and final sum of a row.
    always_comb begin
        w_bias_term = (i_cfg.bias_en && r_bias_vld[r_row]) ?
                      (ACC_W'(r_bq) <<< 8) : '0;
        w_final     = r_acc + w_bias_term;
    end

    // Raw weight store.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_cmd.op == OP_WEIGHT) begin
            r_wmem[{i_q_cmd.row, i_q_cmd.col}] <= i_q_cmd.value;
        end
        r_wq <= r_wmem[{r_row, r_col}];
    end

    // Effective weight store.
    always_ff @(posedge i_clk) begin
        if (w_eff_we) begin
            r_emem[w_eff_wa] <= w_eff_wd;
        end
        r_eq <= r_emem[{r_row, r_col}];
    end

    // Activation buffer.
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_q_cmd.op == OP_ACT || i_q_cmd.op == OP_RUN)) begin
            r_amem[i_q_cmd.col] <= i_q_cmd.value;
        end
        r_aq <= r_amem[r_col];
    end

    // Bias store.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_cmd.op == OP_BIAS) begin
            r_bmem[i_q_cmd.row] <= i_q_cmd.value;
        end
        r_bq <= r_bmem[r_row];
    end

    // Engine state, pipeline and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_ready     <= 1'b0;
            r_bias_vld  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Pipeline tags.
            r_s1_valid <= w_issue;
            r_s1_first <= (r_col == '0);
            r_s1_last  <= w_col_last;
            r_s1_col   <= r_col;
            r_s2_valid <= r_s1_valid;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_col   <= r_s1_col;
            r_s3_valid <= r_s2_valid;
            r_s3_last  <= r_s2_last;

            // Absolute sum for the row scale.
            if (r_s1_valid && (r_state == ST_SUM || r_state == ST_SUM_WAIT)) begin
                r_sum <= (r_s1_first ? '0 : r_sum) + SUM_W'(w_abs);
            end

            // Code times scale, or the raw Q8.8 weight shifted left by 8 to match.
            if (i_cfg.use_bin) begin
                r_bprod <= w_code * $signed({1'b0, r_scale});
            end else begin
                r_bprod <= 33'(r_wq) <<< 8;
            end

            // Multiply and accumulate.
            r_prod <= r_eq * r_aq;
            if (r_s2_valid) begin
                r_acc <= (r_s2_first ? '0 : r_acc) + ACC_W'(r_prod);
            end

            // Output register.
            if (r_s3_valid && r_s3_last && (r_state == ST_DOT_WAIT)) begin
                r_out_valid          <= 1'b1;
                r_out_item.out_index <= r_row;
                r_out_item.out_value <= OUT_W'(w_final);
                r_out_item.last      <= w_row_last;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end

            // Column counter.
            if (w_issue) begin
                r_col <= w_col_last ? '0 : r_col + COL_W'(1);
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_pop) begin
                        unique case (i_q_cmd.op)
                            OP_WEIGHT: r_ready <= 1'b0;
                            OP_BIAS:   r_bias_vld[i_q_cmd.row] <= 1'b1;
                            OP_ACT:    ;
                            OP_RUN: begin
                                r_row <= '0;
                                r_col <= '0;
                                r_scale <= 16'd256;
                                if (r_ready) begin
                                    r_state <= ST_DOT;
                                end else if (i_cfg.use_bin && i_cfg.use_scale) begin
                                    r_state <= ST_SUM;
                                end else begin
                                    r_state <= ST_BUILD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SUM: begin
                    if (w_col_last) begin
                        r_state <= ST_SUM_WAIT;
                    end
                end
                ST_SUM_WAIT: begin
                    if (r_s1_valid && r_s1_last) begin
                        r_state <= ST_DIV_START;
                    end
                end
                ST_DIV_START: r_state <= ST_DIV;
                ST_DIV: begin
                    if (i_div_done) begin
                        r_scale <= (i_div_quot > SUM_W'(16'hffff)) ?
                                   16'hffff : i_div_quot[VAL_W-1:0];
                        r_state <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    if (w_col_last) begin
                        r_state <= ST_BUILD_WAIT;
                    end
                end
                ST_BUILD_WAIT: begin
                    if (r_s2_valid && r_s2_last) begin
                        if (w_row_last) begin
                            r_ready <= 1'b1;
                            r_row   <= '0;
                            r_state <= ST_DOT;
                        end else begin
                            r_row   <= r_row + ROW_W'(1);
                            r_state <= (i_cfg.use_bin && i_cfg.use_scale) ?
                                       ST_SUM : ST_BUILD;
                        end
                    end
                end
                ST_DOT: begin
                    if (w_issue && w_col_last) begin
                        r_state <= ST_DOT_WAIT;
                    end
                end
                ST_DOT_WAIT: begin
                    if (r_s3_valid && r_s3_last) begin
                        if (w_row_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_row   <= r_row + ROW_W'(1);
                            r_state <= ST_DOT;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/binary_weight_fully_connected.sv
// ----------------------------------------------------------------------------
// binary_weight_fully_connected
// Fully connected layer with Q8.8 weights, binarised when enabled, and Q32.16 results.
// ----------------------------------------------------------------------------
// Input beats (valid/stall) load a weight, a bias or one activation element.
// A weight, bias or plain activation beat is absorbed from the queue when
// the engine is idle; a short queue lets up to four beats wait while the
// engine is busy. The activation at position k_in_use-1 starts a run of
// n_in_use result beats, in row order, with last set on the final one.
// Run time is set by the single multiply-accumulate unit reading one
// effective weight a cycle, except while a stalled result holds the start
// of a row. After any weight load the first run also rebuilds the effective
// weights (absolute sum pass, divider and a build pass per row; without
// scaling only the build pass).
// After reset the effective weight store is cleared, one entry a cycle,
// over all 65536 entries, while input is stalled; the APB port works throughout.
// When the receiver stalls, the finished result holds in the output register
// and the engine waits before the next row, while input beats still queue.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_weight_fully_connected (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire bwfc_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output bwfc_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import bwfc_pkg::*;

    logic                    r_use_bin;
    logic                    r_use_scale;
    logic signed [VAL_W-1:0] r_pos;
    logic signed [VAL_W-1:0] r_neg;
    logic                    r_bias_en;
    logic [K_W-1:0]          r_k;
    logic [N_W-1:0]          r_n;
    t_cfg                    w_cfg;
    logic                    w_wr;
    logic                    w_push;
    t_cmd                    w_push_cmd;
    logic                    w_pop;
    t_cmd                    w_q_cmd;
    logic                    w_q_empty;
    logic                    w_q_full;
    logic                    w_clearing;
    logic                    w_div_start;
    logic [SUM_W-1:0]        w_div_dividend;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_div_quot;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_bin   <= 1'b1;
            r_use_scale <= 1'b1;
            r_pos       <= 16'sd256;
            r_neg       <= -16'sd256;
            r_bias_en   <= 1'b1;
            r_k         <= K_W'(1024);
            r_n         <= N_W'(64);
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_USE_BIN:  r_use_bin   <= pwdata[0];
                REG_USE_SCL:  r_use_scale <= pwdata[0];
                REG_POS_VAL:  r_pos       <= pwdata[VAL_W-1:0];
                REG_NEG_VAL:  r_neg       <= pwdata[VAL_W-1:0];
                REG_BIAS_EN:  r_bias_en   <= pwdata[0];
                REG_K_IN_USE: r_k         <= pwdata[K_W-1:0];
                REG_N_IN_USE: r_n         <= pwdata[N_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[4:2])
            REG_USE_BIN:  prdata = 32'(r_use_bin);
            REG_USE_SCL:  prdata = 32'(r_use_scale);
            REG_POS_VAL:  prdata = 32'(r_pos);
            REG_NEG_VAL:  prdata = 32'(r_neg);
            REG_BIAS_EN:  prdata = 32'(r_bias_en);
            REG_K_IN_USE: prdata = 32'(r_k);
            REG_N_IN_USE: prdata = 32'(r_n);
            default:      prdata = '0;
        endcase
    end

    // Lengths clamped to the layer size, with zero taken as one.
    always_comb begin
        w_cfg.use_bin   = r_use_bin;
        w_cfg.use_scale = r_use_scale;
        w_cfg.pos_value = r_pos;
        w_cfg.neg_value = r_neg;
        w_cfg.bias_en   = r_bias_en;
        if (r_k == '0) begin
            w_cfg.k_eff = K_W'(1);
        end else if (r_k > K_W'(MAX_INPUTS)) begin
            w_cfg.k_eff = K_W'(MAX_INPUTS);
        end else begin
            w_cfg.k_eff = r_k;
        end
        if (r_n == '0) begin
            w_cfg.n_eff = N_W'(1);
        end else if (r_n > N_W'(MAX_OUTPUTS)) begin
            w_cfg.n_eff = N_W'(MAX_OUTPUTS);
        end else begin
            w_cfg.n_eff = r_n;
        end
    end

    bwfc_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .i_cfg      (w_cfg),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    bwfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    bwfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_cfg.k_eff),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    bwfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_empty      (w_q_empty),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_pop),
        .o_clearing     (w_clearing),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .i_div_done     (w_div_done),
        .i_div_quot     (w_div_quot),
        .o_out_valid    (o_out_valid),
        .o_out_item     (o_out_item),
        .i_out_stall    (i_out_stall)
    );

`ifndef SYNTHESIS
    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("command queue overflow");

    // No beat is taken while the effective weight store is being cleared.
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_in_stall)
        else $error("input accepted during clearing pass");

    // No result appears before the clearing pass has finished.
    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_out_valid)
        else $error("result during clearing pass");

    // The engine never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
